/* design/dbbf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dbbf_pkg
// Types, codes and constants shared by the dual BIOS boot failover block.
// ----------------------------------------------------------------------------
package dbbf_pkg;

    localparam int TIMER_BITS  = 24;
    localparam int CFG_BITS    = 24;
    localparam int APB_DATA    = 32;
    localparam int APB_ADDR    = 3;
    localparam int MAX_RESULTS = 4;
    localparam int SLOT_BITS   = $clog2(MAX_RESULTS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_BITS-1:0] START_TICKS_RESET = CFG_BITS'(10000);
    localparam logic [CFG_BITS-1:0] END_TICKS_RESET   = CFG_BITS'(300000);

    localparam logic [15:0] CODE_IDLE        = 16'h00FF;
    localparam logic [15:0] CODE_MBIST_START = 16'hE336;
    localparam logic [15:0] CODE_MBIST_DONE  = 16'hE337;

    // Register indexes on the configuration port.
    localparam logic REG_START_TICKS = 1'b0;
    localparam logic REG_END_TICKS   = 1'b1;

    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_LPC_RESET = 3'd1,
        ACT_POST_CODE = 3'd2,
        ACT_END_POST  = 3'd3,
        ACT_WATCHDOG  = 3'd4,
        ACT_SELECT    = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        KIND_FAIL     = 3'd0,
        KIND_SWITCH   = 3'd1,
        KIND_MB_START = 3'd2,
        KIND_MB_DONE  = 3'd3,
        KIND_PWR_OFF  = 3'd4,
        KIND_PWR_ON   = 3'd5,
        KIND_MB_WRITE = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_START    = 2'd1,
        CAUSE_END      = 2'd2,
        CAUSE_WATCHDOG = 2'd3
    } cause_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] start_ticks;
        logic [CFG_BITS-1:0] end_ticks;
    } cfg_t;

    typedef struct packed {
        kind_t  kind;
        cause_t cause;
        logic   bios;
    } result_t;

    // One queued run: the results caused by one item and the index of its final one.
    typedef struct packed {
        logic [SLOT_BITS-1:0]         last_idx;
        result_t [MAX_RESULTS-1:0]    slot;
    } run_t;

    typedef struct packed {
        logic valid;
        run_t run;
    } qhead_t;

endpackage
`default_nettype wire

/* design/dbbf_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dbbf_in_if
// Input event channel: valid/ready handshake with the event payload.
// ----------------------------------------------------------------------------
interface dbbf_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic        signal_value;
    logic [15:0] post_code;
    logic        mbist_status_zero;
    logic        host_power_on;
    logic        post_reached_standby;
    logic        select_value;
    logic        log_enable;

    modport source (
        output valid, action, signal_value, post_code, mbist_status_zero,
               host_power_on, post_reached_standby, select_value, log_enable,
        input  ready
    );

    modport sink (
        input  valid, action, signal_value, post_code, mbist_status_zero,
               host_power_on, post_reached_standby, select_value, log_enable,
        output ready
    );
endinterface
`default_nettype wire

/* design/dbbf_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dbbf_out_if
// Result channel: valid/ready handshake, one result per transfer; last marks an item's final result.
// ----------------------------------------------------------------------------
interface dbbf_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_kind;
    logic [1:0] cause;
    logic       bios_select;
    logic       last;

    modport source (
        output valid, event_kind, cause, bios_select, last,
        input  ready
    );

    modport sink (
        input  valid, event_kind, cause, bios_select, last,
        output ready
    );
endinterface
`default_nettype wire

/* design/dbbf_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dbbf_front
// Accepts events, keeps the boot timers, self-test flag and BIOS selection,
// and turns each event that yields results into a run for the queue.
// ----------------------------------------------------------------------------
module dbbf_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    dbbf_in_if.sink            in_ch,
    input  wire dbbf_pkg::cfg_t cfg,
    input  wire logic          q_full,
    output logic               push,
    output dbbf_pkg::run_t     push_run
);

    logic [dbbf_pkg::TIMER_BITS-1:0] start_rem_reg, start_rem_next;
    logic [dbbf_pkg::TIMER_BITS-1:0] end_rem_reg, end_rem_next;
    logic                            start_armed_reg, start_armed_next;
    logic                            end_armed_reg, end_armed_next;
    logic                            mbist_reg, mbist_next;
    logic                            bios_reg, bios_next;

    logic                            accept;
    logic [2:0]                      n_results;
    logic                            fail_go;
    logic                            fail_pwr;
    dbbf_pkg::cause_t                fail_cause;
    logic [dbbf_pkg::TIMER_BITS-1:0] start_load;
    logic [dbbf_pkg::TIMER_BITS-1:0] end_load;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;
    assign start_load  = dbbf_pkg::TIMER_BITS'(cfg.start_ticks);
    assign end_load    = dbbf_pkg::TIMER_BITS'(cfg.end_ticks);

    always_comb
    begin
        start_rem_next   = start_rem_reg;
        end_rem_next     = end_rem_reg;
        start_armed_next = start_armed_reg;
        end_armed_next   = end_armed_reg;
        mbist_next       = mbist_reg;
        bios_next        = bios_reg;
        push_run         = '0;
        n_results        = 3'd0;
        fail_go          = 1'b0;
        fail_pwr         = 1'b0;
        fail_cause       = dbbf_pkg::CAUSE_NONE;

        if (accept)
        begin
            case (dbbf_pkg::action_t'(in_ch.action))
                dbbf_pkg::ACT_TICK:
                begin
                    if (start_armed_reg)
                    begin
                        if (start_rem_reg <= dbbf_pkg::TIMER_BITS'(1))
                        begin
                            start_armed_next = 1'b0;
                            start_rem_next   = '0;
                            // A start failure that acts stops the end timer too.
                            if (in_ch.host_power_on)
                            begin
                                end_armed_next = 1'b0;
                                end_rem_next   = '0;
                                fail_go        = 1'b1;
                                fail_pwr       = 1'b1;
                                fail_cause     = dbbf_pkg::CAUSE_START;
                            end
                        end
                        else
                        begin
                            start_rem_next = start_rem_reg - dbbf_pkg::TIMER_BITS'(1);
                        end
                    end
                    if (end_armed_next)
                    begin
                        if (end_rem_reg <= dbbf_pkg::TIMER_BITS'(1))
                        begin
                            end_armed_next = 1'b0;
                            end_rem_next   = '0;
                            if (in_ch.host_power_on && !in_ch.post_reached_standby)
                            begin
                                fail_go    = 1'b1;
                                fail_pwr   = 1'b1;
                                fail_cause = dbbf_pkg::CAUSE_END;
                            end
                        end
                        else
                        begin
                            end_rem_next = end_rem_reg - dbbf_pkg::TIMER_BITS'(1);
                        end
                    end
                end
                dbbf_pkg::ACT_LPC_RESET:
                begin
                    if (in_ch.signal_value)
                    begin
                        start_rem_next   = start_load;
                        start_armed_next = 1'b1;
                        end_rem_next     = end_load;
                        end_armed_next   = 1'b1;
                        mbist_next       = 1'b0;
                    end
                end
                dbbf_pkg::ACT_POST_CODE:
                begin
                    if (in_ch.post_code != dbbf_pkg::CODE_IDLE)
                    begin
                        start_armed_next = 1'b0;
                    end
                    if (in_ch.post_code == dbbf_pkg::CODE_MBIST_START &&
                        in_ch.mbist_status_zero)
                    begin
                        push_run.slot[0] = '{dbbf_pkg::KIND_MB_START,
                                             dbbf_pkg::CAUSE_NONE, bios_reg};
                        n_results        = 3'd1;
                        mbist_next       = 1'b1;
                        end_armed_next   = 1'b0;
                    end
                    else if (mbist_reg && in_ch.post_code == dbbf_pkg::CODE_MBIST_DONE)
                    begin
                        push_run.slot[0] = '{dbbf_pkg::KIND_MB_DONE,
                                             dbbf_pkg::CAUSE_NONE, bios_reg};
                        push_run.slot[1] = '{dbbf_pkg::KIND_MB_WRITE,
                                             dbbf_pkg::CAUSE_NONE, bios_reg};
                        n_results        = 3'd2;
                        mbist_next       = 1'b0;
                        end_rem_next     = end_load;
                        end_armed_next   = 1'b1;
                    end
                end
                dbbf_pkg::ACT_END_POST:
                begin
                    if (in_ch.signal_value)
                    begin
                        end_armed_next = 1'b0;
                    end
                end
                dbbf_pkg::ACT_WATCHDOG:
                begin
                    if (in_ch.signal_value)
                    begin
                        end_armed_next = 1'b0;
                        if (in_ch.host_power_on)
                        begin
                            fail_go    = 1'b1;
                            fail_cause = dbbf_pkg::CAUSE_WATCHDOG;
                        end
                    end
                end
                dbbf_pkg::ACT_SELECT:
                begin
                    bios_next = in_ch.select_value;
                    if (in_ch.log_enable)
                    begin
                        push_run.slot[0] = '{dbbf_pkg::KIND_SWITCH,
                                             dbbf_pkg::CAUSE_NONE, in_ch.select_value};
                        n_results        = 3'd1;
                    end
                end
                default:
                begin
                end
            endcase

            // At most one failure acts per item; it builds the whole run.
            if (fail_go)
            begin
                push_run.slot[0] = '{dbbf_pkg::KIND_FAIL, fail_cause, bios_reg};
                n_results        = 3'd1;
                if (!bios_reg)
                begin
                    bios_next = 1'b1;
                    if (fail_pwr)
                    begin
                        push_run.slot[1] = '{dbbf_pkg::KIND_PWR_OFF,
                                             dbbf_pkg::CAUSE_NONE, 1'b0};
                        push_run.slot[2] = '{dbbf_pkg::KIND_SWITCH,
                                             dbbf_pkg::CAUSE_NONE, 1'b1};
                        push_run.slot[3] = '{dbbf_pkg::KIND_PWR_ON,
                                             dbbf_pkg::CAUSE_NONE, 1'b1};
                        n_results        = 3'd4;
                    end
                    else
                    begin
                        push_run.slot[1] = '{dbbf_pkg::KIND_SWITCH,
                                             dbbf_pkg::CAUSE_NONE, 1'b1};
                        n_results        = 3'd2;
                    end
                end
            end
        end

        push_run.last_idx = dbbf_pkg::SLOT_BITS'(n_results - 3'd1);
    end

    assign push = accept && (n_results != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_rem_reg   <= '0;
            end_rem_reg     <= '0;
            start_armed_reg <= 1'b0;
            end_armed_reg   <= 1'b0;
            mbist_reg       <= 1'b0;
            bios_reg        <= 1'b0;
        end
        else
        begin
            start_rem_reg   <= start_rem_next;
            end_rem_reg     <= end_rem_next;
            start_armed_reg <= start_armed_next;
            end_armed_reg   <= end_armed_next;
            mbist_reg       <= mbist_next;
            bios_reg        <= bios_next;
        end
    end

endmodule
`default_nettype wire

/* design/dbbf_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dbbf_queue
// Short FIFO of result runs between the event front end and the result
// sequencer.
// ----------------------------------------------------------------------------
module dbbf_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire dbbf_pkg::run_t push_run,
    output logic              full,
    input  wire logic         pop,
    output dbbf_pkg::qhead_t  head
);

    dbbf_pkg::run_t                   mem [dbbf_pkg::QUEUE_DEPTH];
    logic [dbbf_pkg::QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [dbbf_pkg::QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [dbbf_pkg::QCNT_BITS-1:0]   count_reg, count_next;
    logic                             do_push;
    logic                             do_pop;

    assign full       = (count_reg == dbbf_pkg::QCNT_BITS'(dbbf_pkg::QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.run   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == dbbf_pkg::QPTR_BITS'(dbbf_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + dbbf_pkg::QPTR_BITS'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == dbbf_pkg::QPTR_BITS'(dbbf_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + dbbf_pkg::QPTR_BITS'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + dbbf_pkg::QCNT_BITS'(1);
            2'b01:   count_next = count_reg - dbbf_pkg::QCNT_BITS'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

/* design/dbbf_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dbbf_back
// Walks the run at the queue head and presents its results one per cycle
// through the output register while the receiver is ready.
// ----------------------------------------------------------------------------
module dbbf_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire dbbf_pkg::qhead_t head,
    output logic               pop,
    dbbf_out_if.source         out_ch
);

    logic [dbbf_pkg::SLOT_BITS-1:0] idx_reg, idx_next;
    logic                           valid_reg, valid_next;
    dbbf_pkg::result_t              res_reg, res_next;
    logic                           last_reg, last_next;
    logic                           load;
    logic                           at_last;

    assign load    = head.valid && (!valid_reg || out_ch.ready);
    assign at_last = (idx_reg == head.run.last_idx);
    assign pop     = load && at_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        res_next   = res_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            res_next   = head.run.slot[idx_reg];
            last_next  = at_last;
            idx_next   = at_last ? '0 : idx_reg + dbbf_pkg::SLOT_BITS'(1);
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        last_reg <= last_next;
    end

    assign out_ch.valid       = valid_reg;
    assign out_ch.event_kind  = res_reg.kind;
    assign out_ch.cause       = res_reg.cause;
    assign out_ch.bios_select = res_reg.bios;
    assign out_ch.last        = last_reg;

endmodule
`default_nettype wire

/* design/dual_bios_boot_failover.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dual_bios_boot_failover
// Boot watchdog for a host with two BIOS images: tracks start and end of POST
// timers and fails over to the backup BIOS when boot stalls.
// ----------------------------------------------------------------------------
// Usage:
// in_ch takes one event per item (tick, LPC reset, POST code, end of POST,
// watchdog timeout, manual select). out_ch gives zero to four results per
// item; the final result of an item carries last. The APB port holds the
// start and end timeout registers (byte addresses 0 and 4); write them only
// while the block is idle. pready is always high.
// Flow: the first result of an item passes through the run queue and then
// the output register. The output register delivers one result per cycle
// while the receiver is ready, and an item has at most four results; an item
// with no results puts nothing on out_ch. A two-entry run queue lets events be
// accepted every cycle while the queue is not full and earlier results drain.
// Reset clears both timers, the self-test flag and selects the primary BIOS;
// the timeout registers return to 10000 and 300000 ticks. When the receiver
// stalls, the held result stays in place, the queue fills, and in_ch.ready
// drops once two runs are waiting.
// ----------------------------------------------------------------------------
module dual_bios_boot_failover (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    dbbf_in_if.sink                            in_ch,
    dbbf_out_if.source                         out_ch,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dbbf_pkg::APB_ADDR-1:0] paddr,
    input  wire logic [dbbf_pkg::APB_DATA-1:0] pwdata,
    output logic      [dbbf_pkg::APB_DATA-1:0] prdata,
    output logic                               pready
);

    logic [dbbf_pkg::CFG_BITS-1:0] start_ticks_reg;
    logic [dbbf_pkg::CFG_BITS-1:0] end_ticks_reg;
    logic                          cfg_wr;
    logic                          reg_sel;
    dbbf_pkg::cfg_t                cfg;
    logic                          q_full;
    logic                          push;
    dbbf_pkg::run_t                push_run;
    logic                          pop;
    dbbf_pkg::qhead_t              head;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = (reg_sel == dbbf_pkg::REG_END_TICKS)
                     ? dbbf_pkg::APB_DATA'(end_ticks_reg)
                     : dbbf_pkg::APB_DATA'(start_ticks_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_ticks_reg <= dbbf_pkg::START_TICKS_RESET;
            end_ticks_reg   <= dbbf_pkg::END_TICKS_RESET;
        end
        else if (cfg_wr)
        begin
            if (reg_sel == dbbf_pkg::REG_START_TICKS)
            begin
                start_ticks_reg <= pwdata[dbbf_pkg::CFG_BITS-1:0];
            end
            else
            begin
                end_ticks_reg <= pwdata[dbbf_pkg::CFG_BITS-1:0];
            end
        end
    end

    assign cfg.start_ticks = start_ticks_reg;
    assign cfg.end_ticks   = end_ticks_reg;

    dbbf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .cfg      (cfg),
        .q_full   (q_full),
        .push     (push),
        .push_run (push_run)
    );

    dbbf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (push_run),
        .full     (q_full),
        .pop      (pop),
        .head     (head)
    );

    dbbf_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .out_ch (out_ch)
    );

`ifndef SYNTHESIS
    // Only a boot fail log carries a cause.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.cause != dbbf_pkg::CAUSE_NONE
        |-> out_ch.event_kind == dbbf_pkg::KIND_FAIL)
        else $error("cause set on a result that is not a boot fail log");

    // A power off request is always followed at once by the switch to backup.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready && out_ch.event_kind == dbbf_pkg::KIND_PWR_OFF
        |=> out_ch.valid && out_ch.event_kind == dbbf_pkg::KIND_SWITCH
            && out_ch.bios_select)
        else $error("power off not followed by a switch to the backup BIOS");

    // Power on is only requested after failing over to the backup BIOS.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.event_kind == dbbf_pkg::KIND_PWR_ON
        |-> out_ch.bios_select && out_ch.last)
        else $error("power on result without backup BIOS or not final");
`endif

endmodule
`default_nettype wire

/* verif/dual_bios_boot_failover_tb.sv */
// ----------------------------------------------------------------------------
// dual_bios_boot_failover_tb
// Self-checking bench for the dual BIOS boot failover block. Boot event items
// go in through a bursty sender, and a predictor of the timers, the self-test
// flag and the BIOS selection works out the results of each item. A checker
// compares every result taken from the stalling receiver with the oldest
// prediction. Directed events come first, then random boot sequences and
// noise under several timeout settings.
// ----------------------------------------------------------------------------
module dual_bios_boot_failover_tb;
    import dbbf_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int DRAIN_CYCLES   = 20;

    localparam logic [CFG_BITS-1:0] TICKS_MAX = {CFG_BITS{1'b1}};

    // Action codes that the block has to ignore.
    localparam logic [2:0] ACT_RESERVED_A = 3'd6;
    localparam logic [2:0] ACT_RESERVED_B = 3'd7;

    typedef struct packed {
        logic [2:0]  action;
        logic        sig;
        logic [15:0] code;
        logic        mb_zero;
        logic        host_on;
        logic        standby;
        logic        sel;
        logic        log_en;
    } boot_event_t;

    typedef struct packed {
        kind_t  kind;
        cause_t cause;
        logic   bios;
        logic   last;
    } failover_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_ADDR-1:0] paddr;
    logic [APB_DATA-1:0] pwdata;
    logic [APB_DATA-1:0] prdata;
    logic                pready;
    logic                rx_ready = 1'b0;

    dbbf_in_if  ev_ch ();
    dbbf_out_if res_ch ();

    assign res_ch.ready = rx_ready;

    dual_bios_boot_failover u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (ev_ch),
        .out_ch  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predicted state of the block.
    logic [CFG_BITS-1:0]   cfg_start_ticks = START_TICKS_RESET;
    logic [CFG_BITS-1:0]   cfg_end_ticks   = END_TICKS_RESET;
    logic [TIMER_BITS-1:0] start_left      = '0;
    logic [TIMER_BITS-1:0] end_left        = '0;
    logic                  start_running   = 1'b0;
    logic                  end_running     = 1'b0;
    logic                  selftest_on     = 1'b0;
    logic                  bios_sel        = 1'b0;

    failover_result_t pending_results[$];
    failover_result_t item_results[$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int burst_left     = 0;
    int idle_cycles    = 0;
    int rx_mode        = 0;
    int rx_left        = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void add_result(kind_t kind, cause_t cause);
        failover_result_t r;
        if (item_results.size() < MAX_RESULTS)
        begin
            r.kind  = kind;
            r.cause = cause;
            r.bios  = bios_sel;
            r.last  = 1'b0;
            item_results.push_back(r);
        end
    endfunction

    function automatic void report_boot_failure(cause_t cause, logic power_ctl, logic host_on);
        if (!host_on)
            return;
        add_result(KIND_FAIL, cause);
        // On the backup image there is nothing left to fail over to.
        if (bios_sel != 1'b0)
            return;
        if (power_ctl)
            add_result(KIND_PWR_OFF, CAUSE_NONE);
        bios_sel = 1'b1;
        add_result(KIND_SWITCH, CAUSE_NONE);
        if (power_ctl)
            add_result(KIND_PWR_ON, CAUSE_NONE);
    endfunction

    function automatic void predict_failover(boot_event_t ev);
        logic             start_fired;
        logic             end_fired;
        failover_result_t r;
        item_results.delete();
        start_fired = 1'b0;
        end_fired   = 1'b0;
        case (ev.action)
            ACT_TICK:
            begin
                if (start_running)
                begin
                    if (start_left <= 1)
                    begin
                        start_left    = '0;
                        start_running = 1'b0;
                        start_fired   = 1'b1;
                    end
                    else
                        start_left = start_left - 1'b1;
                end
                // A start timeout that acts also stops the end timer.
                if (start_fired && ev.host_on)
                begin
                    end_running = 1'b0;
                    end_left    = '0;
                    report_boot_failure(CAUSE_START, 1'b1, ev.host_on);
                end
                if (end_running)
                begin
                    if (end_left <= 1)
                    begin
                        end_left    = '0;
                        end_running = 1'b0;
                        end_fired   = 1'b1;
                    end
                    else
                        end_left = end_left - 1'b1;
                end
                if (end_fired && ev.host_on && !ev.standby)
                    report_boot_failure(CAUSE_END, 1'b1, ev.host_on);
            end
            ACT_LPC_RESET:
            begin
                if (ev.sig)
                begin
                    start_left    = TIMER_BITS'(cfg_start_ticks);
                    start_running = 1'b1;
                    end_left      = TIMER_BITS'(cfg_end_ticks);
                    end_running   = 1'b1;
                    selftest_on   = 1'b0;
                end
            end
            ACT_POST_CODE:
            begin
                if (ev.code != CODE_IDLE)
                    start_running = 1'b0;
                if (ev.code == CODE_MBIST_START && ev.mb_zero)
                begin
                    add_result(KIND_MB_START, CAUSE_NONE);
                    selftest_on = 1'b1;
                    end_running = 1'b0;
                end
                if (selftest_on && ev.code == CODE_MBIST_DONE)
                begin
                    add_result(KIND_MB_DONE, CAUSE_NONE);
                    selftest_on = 1'b0;
                    end_left    = TIMER_BITS'(cfg_end_ticks);
                    end_running = 1'b1;
                    add_result(KIND_MB_WRITE, CAUSE_NONE);
                end
            end
            ACT_END_POST:
            begin
                if (ev.sig)
                    end_running = 1'b0;
            end
            ACT_WATCHDOG:
            begin
                if (ev.sig)
                begin
                    end_running = 1'b0;
                    report_boot_failure(CAUSE_WATCHDOG, 1'b0, ev.host_on);
                end
            end
            ACT_SELECT:
            begin
                bios_sel = ev.sel;
                if (ev.log_en)
                    add_result(KIND_SWITCH, CAUSE_NONE);
            end
            default:
                ;
        endcase
        if (item_results.size() > 0)
        begin
            r      = item_results.pop_back();
            r.last = 1'b1;
            item_results.push_back(r);
        end
        while (item_results.size() > 0)
            pending_results.push_back(item_results.pop_front());
    endfunction

    // ------------------------------------------------------------------
    // Result checker, receiver stalls and watchdog
    // ------------------------------------------------------------------
    function automatic void log_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endfunction

    always @(posedge clk)
    begin : result_check
        failover_result_t want;
        if (rst_n && res_ch.valid && rx_ready)
        begin
            if (pending_results.size() == 0)
                log_mismatch($sformatf("unexpected result: kind %0d cause %0d bios %0b last %0b",
                                       res_ch.event_kind, res_ch.cause, res_ch.bios_select,
                                       res_ch.last));
            else
            begin
                want = pending_results.pop_front();
                if (res_ch.event_kind !== want.kind || res_ch.cause !== want.cause ||
                    res_ch.bios_select !== want.bios || res_ch.last !== want.last)
                    log_mismatch($sformatf({"result mismatch: expected kind %0d cause %0d ",
                                            "bios %0b last %0b, got kind %0d cause %0d ",
                                            "bios %0b last %0b"},
                                           want.kind, want.cause, want.bios, want.last,
                                           res_ch.event_kind, res_ch.cause,
                                           res_ch.bios_select, res_ch.last));
            end
        end
    end

    // The receiver switches at random between four stall patterns.
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 80);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_mode)
            0:       rx_ready <= 1'b1;
            1:       rx_ready <= ($urandom_range(0, 1) == 1);
            2:       rx_ready <= (rx_left % 4 == 0);
            default: rx_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((ev_ch.valid && ev_ch.ready) || (res_ch.valid && rx_ready) || psel)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_event(boot_event_t ev);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(0, 4);
            if (gap > 0)
            begin
                ev_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        ev_ch.valid                <= 1'b1;
        ev_ch.action               <= ev.action;
        ev_ch.signal_value         <= ev.sig;
        ev_ch.post_code            <= ev.code;
        ev_ch.mbist_status_zero    <= ev.mb_zero;
        ev_ch.host_power_on        <= ev.host_on;
        ev_ch.post_reached_standby <= ev.standby;
        ev_ch.select_value         <= ev.sel;
        ev_ch.log_enable           <= ev.log_en;
        do
            @(posedge clk);
        while (!ev_ch.ready);
        predict_failover(ev);
        // Ignored items do not count toward the stimulus length.
        if (ev.action <= ACT_SELECT &&
            !(ev.sig == 1'b0 && (ev.action == ACT_LPC_RESET || ev.action == ACT_END_POST ||
                                 ev.action == ACT_WATCHDOG)))
            items_sent++;
    endtask

    task automatic wait_idle();
        ev_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // Items without results may still be inside the block.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeouts(logic [CFG_BITS-1:0] start_ticks,
                                  logic [CFG_BITS-1:0] end_ticks);
        logic [CFG_BITS-1:0] value;
        for (int i = 0; i < 2; i++)
        begin
            value = (i == 0) ? start_ticks : end_ticks;
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= (i == 0) ? {REG_START_TICKS, 2'b00} : {REG_END_TICKS, 2'b00};
            pwdata  <= {8'($urandom), value};
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_start_ticks = start_ticks;
        cfg_end_ticks   = end_ticks;
    endtask

    function automatic boot_event_t make_event(logic [2:0] action, logic sig, logic [15:0] code,
                                               logic mb_zero, logic host_on, logic standby,
                                               logic sel, logic log_en);
        boot_event_t ev;
        ev.action  = action;
        ev.sig     = sig;
        ev.code    = code;
        ev.mb_zero = mb_zero;
        ev.host_on = host_on;
        ev.standby = standby;
        ev.sel     = sel;
        ev.log_en  = log_en;
        return ev;
    endfunction

    function automatic boot_event_t random_event(logic [2:0] action);
        return make_event(action, $urandom_range(0, 7) != 0, 16'($urandom), 1'($urandom),
                          $urandom_range(0, 7) != 0, $urandom_range(0, 4) == 0,
                          1'($urandom), 1'($urandom));
    endfunction

    function automatic int tick_span(logic [CFG_BITS-1:0] ticks);
        return (ticks > 8) ? 10 : int'(ticks) + 1;
    endfunction

    task automatic send_ticks(int count);
        repeat (count) send_event(random_event(ACT_TICK));
    endtask

    task automatic send_noise(int count);
        boot_event_t ev;
        repeat (count)
        begin
            ev = random_event(3'($urandom));
            case ($urandom_range(0, 5))
                0:       ev.code = CODE_IDLE;
                1:       ev.code = CODE_MBIST_START;
                2:       ev.code = CODE_MBIST_DONE;
                default: ;
            endcase
            send_event(ev);
        end
    endtask

    // One boot attempt: usually a select of the primary BIOS, an LPC reset, then a
    // stalled, normal, self-test or watchdog path with random ticks in between.
    task automatic run_boot_sequence();
        boot_event_t ev;
        int          plan;
        if ($urandom_range(0, 9) < 7)
        begin
            ev     = random_event(ACT_SELECT);
            ev.sel = 1'b0;
            send_event(ev);
        end
        ev     = random_event(ACT_LPC_RESET);
        ev.sig = 1'b1;
        send_event(ev);
        plan = $urandom_range(0, 3);
        if (plan == 0)
            send_ticks($urandom_range(0, tick_span(cfg_start_ticks)));
        else
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                ev      = random_event(ACT_POST_CODE);
                ev.code = CODE_IDLE;
                send_event(ev);
            end
            send_ticks($urandom_range(0, tick_span(cfg_start_ticks)));
            ev = random_event(ACT_POST_CODE);
            if (plan == 2)
                ev.code = CODE_MBIST_START;
            send_event(ev);
            if (plan == 2)
            begin
                send_ticks($urandom_range(0, 2));
                if ($urandom_range(0, 3) != 0)
                begin
                    ev      = random_event(ACT_POST_CODE);
                    ev.code = CODE_MBIST_DONE;
                    send_event(ev);
                end
            end
            send_ticks($urandom_range(0, tick_span(cfg_end_ticks)));
            if (plan == 3)
                ev = random_event(ACT_WATCHDOG);
            else
                ev = random_event(ACT_END_POST);
            send_event(ev);
            send_ticks($urandom_range(0, 3));
        end
    endtask

    task automatic run_phase(logic [CFG_BITS-1:0] start_ticks, logic [CFG_BITS-1:0] end_ticks,
                             int n_items, int noise_pct);
        int target;
        wait_idle();
        write_timeouts(start_ticks, end_ticks);
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_noise($urandom_range(1, 4));
            else
                run_boot_sequence();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_events();
        wait_idle();
        write_timeouts(24'd1, 24'd2);
        send_event(make_event(ACT_SELECT, 0, 16'h0000, 0, 1, 0, 0, 1));
        send_event(make_event(ACT_LPC_RESET, 0, 16'h0000, 0, 1, 0, 0, 0));
        send_event(make_event(ACT_LPC_RESET, 1, 16'h0000, 0, 1, 0, 0, 0));
        send_event(make_event(ACT_POST_CODE, 0, CODE_IDLE, 0, 1, 0, 0, 0));
        // Start timer runs out with the host off; the end timer keeps going.
        send_event(make_event(ACT_TICK, 0, 16'h0000, 0, 0, 0, 0, 0));
        send_event(make_event(ACT_TICK, 0, 16'h0000, 0, 1, 0, 0, 0));
        // Already on the backup image, so only the failure log comes out.
        send_event(make_event(ACT_WATCHDOG, 1, 16'h0000, 0, 1, 0, 0, 0));
        send_event(make_event(ACT_SELECT, 0, 16'h0000, 0, 1, 0, 0, 0));
        send_event(make_event(ACT_LPC_RESET, 1, 16'h0000, 0, 1, 0, 0, 0));
        send_event(make_event(ACT_TICK, 0, 16'h0000, 0, 1, 0, 0, 0));
        send_event(make_event(ACT_TICK, 0, 16'h0000, 0, 1, 0, 0, 0));
        send_event(make_event(ACT_SELECT, 0, 16'h0000, 0, 1, 0, 0, 0));
        send_event(make_event(ACT_LPC_RESET, 1, 16'h0000, 0, 1, 0, 0, 0));
        send_event(make_event(ACT_POST_CODE, 0, 16'h0000, 0, 1, 0, 0, 0));
        send_event(make_event(ACT_POST_CODE, 0, CODE_MBIST_START, 0, 1, 0, 0, 0));
        send_event(make_event(ACT_POST_CODE, 0, CODE_MBIST_START, 1, 1, 0, 0, 0));
        send_event(make_event(ACT_POST_CODE, 0, CODE_MBIST_DONE, 0, 1, 0, 0, 0));
        // End timer expires while POST sits in Standby.
        send_event(make_event(ACT_TICK, 0, 16'h0000, 0, 1, 1, 0, 0));
        send_event(make_event(ACT_TICK, 0, 16'h0000, 0, 1, 1, 0, 0));
        send_event(make_event(ACT_LPC_RESET, 1, 16'h0000, 0, 1, 0, 0, 0));
        send_event(make_event(ACT_END_POST, 0, 16'h0000, 0, 1, 0, 0, 0));
        send_event(make_event(ACT_END_POST, 1, 16'h0000, 0, 1, 0, 0, 0));
        send_event(make_event(ACT_POST_CODE, 0, CODE_MBIST_DONE, 1, 1, 0, 0, 0));
        send_event(make_event(ACT_POST_CODE, 1, 16'hFFFF, 1, 1, 1, 1, 1));
        send_event(make_event(ACT_WATCHDOG, 1, 16'h0000, 0, 0, 0, 0, 0));
        send_event(make_event(ACT_SELECT, 1, 16'hFFFF, 1, 1, 1, 1, 1));
        send_event(make_event(ACT_RESERVED_A, 1, 16'hFFFF, 1, 1, 0, 0, 1));
        send_event(make_event(ACT_RESERVED_B, 1, 16'h0000, 1, 1, 0, 1, 1));
        // Both timers expire on the same tick: only the start timeout acts.
        wait_idle();
        write_timeouts(24'd1, 24'd1);
        send_event(make_event(ACT_SELECT, 0, 16'h0000, 0, 1, 0, 0, 0));
        send_event(make_event(ACT_LPC_RESET, 1, 16'h0000, 0, 1, 0, 0, 0));
        send_event(make_event(ACT_TICK, 0, 16'h0000, 0, 1, 0, 0, 0));
    endtask

    task automatic test_short_timeouts();
        repeat (4) run_phase($urandom_range(1, 6), $urandom_range(1, 8), 50, 15);
    endtask

    task automatic test_timer_extremes();
        run_phase(24'd1, 24'd1, 40, 15);
        run_phase(TICKS_MAX, TICKS_MAX, 40, 20);
        // A zero timeout expires on the first tick, like a timeout of one.
        run_phase(24'd0, 24'd0, 30, 15);
        run_phase(24'd1, TICKS_MAX, 40, 15);
    endtask

    task automatic test_noise_heavy();
        run_phase($urandom_range(1, 4), $urandom_range(1, 4), 40, 60);
    endtask

    initial
    begin
        rst_n                      <= 1'b0;
        psel                       <= 1'b0;
        penable                    <= 1'b0;
        pwrite                     <= 1'b0;
        paddr                      <= '0;
        pwdata                     <= '0;
        ev_ch.valid                <= 1'b0;
        ev_ch.action               <= ACT_TICK;
        ev_ch.signal_value         <= 1'b0;
        ev_ch.post_code            <= '0;
        ev_ch.mbist_status_zero    <= 1'b0;
        ev_ch.host_power_on        <= 1'b0;
        ev_ch.post_reached_standby <= 1'b0;
        ev_ch.select_value         <= 1'b0;
        ev_ch.log_enable           <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_events();
        test_short_timeouts();
        test_timer_extremes();
        test_noise_heavy();

        ev_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
